@@ rtl/ac3sf_pkg.sv @@
// Shared types, status codes and frame-size table for the AC-3 sync-frame deframer.
`default_nettype none

package ac3sf_pkg;

    // Input word: one stream byte or an end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_word_t;

    // Output word: one frame byte or one status report
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic        frame_start;
        logic        frame_end;
        logic [11:0] frame_bytes;
        logic        last_in_run;
    } out_word_t;

    // Header check result handed from the checker to the top level
    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] len;
    } hdr_chk_t;

    // Status codes
    localparam logic [2:0] ST_FRAME    = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC = 3'd1;
    localparam logic [2:0] ST_BAD_RATE = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

    // Header constants
    localparam logic [7:0] SYNC_HI      = 8'h0B;
    localparam logic [7:0] SYNC_LO      = 8'h77;
    localparam logic [1:0] RATE_BAD     = 2'd3;
    localparam logic [1:0] RATE_44K     = 2'd1;
    localparam logic [5:0] SIZE_CODE_MAX = 6'd37;
    localparam int         HDR_LEN      = 5;
    localparam logic [2:0] HDR_LEN_W    = 3'(HDR_LEN);
    localparam logic [2:0] HDR_HELD     = 3'(HDR_LEN - 1);

    // Frame length in 16-bit words by size-code pair and rate code
    function automatic logic [10:0] frame_words(input logic [4:0] idx, input logic [1:0] rate);
        logic [10:0] w48;
        logic [10:0] w44;
        logic [10:0] w32;
        begin
            case (idx)
                5'd0:    begin w48 = 11'd64;   w44 = 11'd69;   w32 = 11'd96;   end
                5'd1:    begin w48 = 11'd80;   w44 = 11'd87;   w32 = 11'd120;  end
                5'd2:    begin w48 = 11'd96;   w44 = 11'd104;  w32 = 11'd144;  end
                5'd3:    begin w48 = 11'd112;  w44 = 11'd121;  w32 = 11'd168;  end
                5'd4:    begin w48 = 11'd128;  w44 = 11'd139;  w32 = 11'd192;  end
                5'd5:    begin w48 = 11'd160;  w44 = 11'd174;  w32 = 11'd240;  end
                5'd6:    begin w48 = 11'd192;  w44 = 11'd208;  w32 = 11'd288;  end
                5'd7:    begin w48 = 11'd224;  w44 = 11'd243;  w32 = 11'd336;  end
                5'd8:    begin w48 = 11'd256;  w44 = 11'd278;  w32 = 11'd384;  end
                5'd9:    begin w48 = 11'd320;  w44 = 11'd348;  w32 = 11'd480;  end
                5'd10:   begin w48 = 11'd384;  w44 = 11'd417;  w32 = 11'd576;  end
                5'd11:   begin w48 = 11'd448;  w44 = 11'd487;  w32 = 11'd672;  end
                5'd12:   begin w48 = 11'd512;  w44 = 11'd557;  w32 = 11'd768;  end
                5'd13:   begin w48 = 11'd640;  w44 = 11'd696;  w32 = 11'd960;  end
                5'd14:   begin w48 = 11'd768;  w44 = 11'd835;  w32 = 11'd1152; end
                5'd15:   begin w48 = 11'd896;  w44 = 11'd975;  w32 = 11'd1344; end
                5'd16:   begin w48 = 11'd1024; w44 = 11'd1114; w32 = 11'd1536; end
                5'd17:   begin w48 = 11'd1152; w44 = 11'd1253; w32 = 11'd1728; end
                5'd18:   begin w48 = 11'd1280; w44 = 11'd1393; w32 = 11'd1920; end
                default: begin w48 = 11'd0;    w44 = 11'd0;    w32 = 11'd0;    end
            endcase
            case (rate)
                2'd0:    frame_words = w48;
                2'd1:    frame_words = w44;
                2'd2:    frame_words = w32;
                default: frame_words = 11'd0;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/ac3sf_hdr_check.sv @@
// Header check and frame-length lookup for one five-byte sync header.
`default_nettype none

module ac3sf_hdr_check (
    input  wire logic [7:0]        hdr0,
    input  wire logic [7:0]        hdr1,
    input  wire logic [7:0]        hdr4,
    output ac3sf_pkg::hdr_chk_t    chk
);
    import ac3sf_pkg::*;

    logic [1:0]  rate;
    logic [5:0]  code;
    logic [10:0] words;
    logic [11:0] len_bytes;

    assign rate = hdr4[7:6];
    assign code = hdr4[5:0];

    // Table lookup, one extra word at 44.1 kHz for odd codes, then bytes
    always_comb
    begin
        words = frame_words(code[5:1], rate);
        if (rate == RATE_44K)
        begin
            words = words + {10'd0, code[0]};
        end
        len_bytes = {words, 1'b0};
    end

    // Checks in priority order: sync, rate, size
    always_comb
    begin
        chk.len = 12'd0;
        if (hdr0 != SYNC_HI || hdr1 != SYNC_LO)
        begin
            chk.status = ST_BAD_SYNC;
        end
        else if (rate == RATE_BAD)
        begin
            chk.status = ST_BAD_RATE;
        end
        else if (code > SIZE_CODE_MAX)
        begin
            chk.status = ST_BAD_SIZE;
        end
        else
        begin
            chk.status = ST_FRAME;
            chk.len    = len_bytes;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ac3_syncframe_deframer.sv @@
// Top level of the AC-3 sync-frame deframer: header capture, burst and pass-through.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_valid / in_ready  | in_data  (data_byte, stream_end)
//  out     | source    | out_valid / out_ready| out_data (byte, status, marks, length)
//
// One input word per cycle while in_ready is high; each result is registered in the output
// register when its word is accepted. A good header gives five results; in_ready stays low
// while the output register drains the header run.
// Reset (rst_n low, asynchronous) clears header count, frame counters and output valid.
// in_ready follows the output register: a stalled result holds in_ready low, also for
// header bytes that give no result.
`default_nettype none

module ac3_syncframe_deframer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ac3sf_pkg::in_word_t   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ac3sf_pkg::out_word_t       out_data
);
    import ac3sf_pkg::*;

    // State
    logic [7:0]  hdr_store_reg [4];
    logic [2:0]  hdr_count_reg;
    logic [2:0]  hdr_count_next;
    logic [11:0] bytes_left_reg;
    logic [11:0] bytes_left_next;
    logic [11:0] cur_len_reg;
    logic [11:0] cur_len_next;
    logic [7:0]  fifth_reg;
    logic [2:0]  burst_cnt_reg;
    logic [2:0]  burst_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;
    out_word_t   out_word_next;

    logic        in_fire;
    logic        out_fire;
    logic        store_we;
    logic        fifth_we;
    hdr_chk_t    chk;
    logic [2:0]  burst_pos;
    logic [7:0]  burst_byte;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = (burst_cnt_reg == 3'd0) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Header check on the held bytes plus the incoming fifth byte
    ac3sf_hdr_check u_hdr_check (
        .hdr0 (hdr_store_reg[0]),
        .hdr1 (hdr_store_reg[1]),
        .hdr4 (in_data.data_byte),
        .chk  (chk)
    );

    // Next byte of the header run
    assign burst_pos  = HDR_LEN_W - burst_cnt_reg;
    assign burst_byte = (burst_pos == HDR_HELD) ? fifth_reg : hdr_store_reg[burst_pos[1:0]];

    // Next-state logic
    always_comb
    begin
        hdr_count_next  = hdr_count_reg;
        bytes_left_next = bytes_left_reg;
        cur_len_next    = cur_len_reg;
        burst_cnt_next  = burst_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        store_we        = 1'b0;
        fifth_we        = 1'b0;

        if (in_fire)
        begin
            if (in_data.stream_end)
            begin
                out_valid_next            = 1'b1;
                out_word_next             = '0;
                out_word_next.status      = (hdr_count_reg == 3'd0 && bytes_left_reg == 12'd0)
                                            ? ST_END : ST_TRUNC;
                out_word_next.last_in_run = 1'b1;
                hdr_count_next            = 3'd0;
                bytes_left_next           = 12'd0;
                cur_len_next              = 12'd0;
            end
            else if (bytes_left_reg != 12'd0)
            begin
                // Frame body pass-through
                out_valid_next            = 1'b1;
                out_word_next.out_byte    = in_data.data_byte;
                out_word_next.status      = ST_FRAME;
                out_word_next.frame_start = 1'b0;
                out_word_next.frame_end   = (bytes_left_reg == 12'd1);
                out_word_next.frame_bytes = cur_len_reg;
                out_word_next.last_in_run = 1'b1;
                bytes_left_next           = bytes_left_reg - 12'd1;
                if (bytes_left_reg == 12'd1)
                begin
                    cur_len_next = 12'd0;
                end
            end
            else if (hdr_count_reg < HDR_HELD)
            begin
                // Hold a header byte, no result
                store_we       = 1'b1;
                hdr_count_next = hdr_count_reg + 3'd1;
            end
            else
            begin
                hdr_count_next = 3'd0;
                out_valid_next = 1'b1;
                if (chk.status != ST_FRAME)
                begin
                    out_word_next             = '0;
                    out_word_next.status      = chk.status;
                    out_word_next.last_in_run = 1'b1;
                end
                else
                begin
                    // Good header: first result now, four more from the burst counter
                    fifth_we                  = 1'b1;
                    cur_len_next              = chk.len;
                    bytes_left_next           = chk.len - 12'(HDR_LEN);
                    burst_cnt_next            = HDR_HELD;
                    out_word_next.out_byte    = hdr_store_reg[0];
                    out_word_next.status      = ST_FRAME;
                    out_word_next.frame_start = 1'b1;
                    out_word_next.frame_end   = 1'b0;
                    out_word_next.frame_bytes = chk.len;
                    out_word_next.last_in_run = 1'b0;
                end
            end
        end
        else if (out_fire && burst_cnt_reg != 3'd0)
        begin
            // Header run: advance one byte per accepted result
            out_valid_next            = 1'b1;
            out_word_next.out_byte    = burst_byte;
            out_word_next.frame_start = 1'b0;
            out_word_next.last_in_run = (burst_cnt_reg == 3'd1);
            burst_cnt_next            = burst_cnt_reg - 3'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg  <= 3'd0;
            bytes_left_reg <= 12'd0;
            cur_len_reg    <= 12'd0;
            burst_cnt_reg  <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_count_reg  <= hdr_count_next;
            bytes_left_reg <= bytes_left_next;
            cur_len_reg    <= cur_len_next;
            burst_cnt_reg  <= burst_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (store_we)
        begin
            hdr_store_reg[hdr_count_reg[1:0]] <= in_data.data_byte;
        end
        if (fifth_we)
        begin
            fifth_reg <= in_data.data_byte;
        end
    end

`ifndef SYNTH
    // No new word is taken while the header run drains
    a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_cnt_reg != 3'd0) |-> !in_ready)
        else $error("input accepted during header run");

    // A pending header run always has a result on the output
    a_burst_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_cnt_reg != 3'd0) |-> out_valid_reg)
        else $error("header run without valid output");

    // The final byte of the header run closes the run
    a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && burst_cnt_reg == 3'd1) |=> (out_valid_reg && out_word_reg.last_in_run))
        else $error("header run not closed by last_in_run");

    // Header capture and frame body never overlap
    a_body_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != 12'd0) |-> (hdr_count_reg == 3'd0))
        else $error("header bytes held inside a frame body");
`endif

endmodule

`default_nettype wire

@@ bench/ac3_syncframe_deframer_tb.sv @@
// Self-checking testbench for the AC-3 sync-frame deframer: directed table, then random streams.
`timescale 1ns / 1ps

module ac3_syncframe_deframer_tb;

    import ac3sf_pkg::*;

    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_ITEMS   = 370;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // rate codes not named in the package
    localparam logic [1:0] RATE_48K = 2'd0;
    localparam logic [1:0] RATE_32K = 2'd2;

    // directed stimulus row; typed rows carry the single status they must produce
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
        logic       typed;
        logic [2:0] st;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_data;

    // frame length in words at 48 kHz and 44.1 kHz, per size-code pair
    int words_48k [19] = '{64, 80, 96, 112, 128, 160, 192, 224, 256, 320,
                           384, 448, 512, 640, 768, 896, 1024, 1152, 1280};
    int words_44k [19] = '{69, 87, 104, 121, 139, 174, 208, 243, 278, 348,
                           417, 487, 557, 696, 835, 975, 1114, 1253, 1393};

    // predictor state
    logic [7:0]  hdr_held [4];
    int          hdr_fill  = 0;
    int          body_left = 0;
    logic [11:0] body_len  = '0;

    out_word_t due_words [$];
    out_word_t want;
    int        mismatches   = 0;
    int        item_count   = 0;
    int        idle_cycles  = 0;
    int        in_idle_pct  = 15;
    int        out_idle_pct = 76;

    ac3_syncframe_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic out_word_t status_word(input logic [2:0] st);
        out_word_t w;
        w             = '0;
        w.status      = st;
        w.last_in_run = 1'b1;
        return w;
    endfunction

    function automatic out_word_t frame_word(input logic [7:0] b, input logic fs,
                                             input logic fe, input logic [11:0] len,
                                             input logic last);
        out_word_t w;
        w             = '0;
        w.out_byte    = b;
        w.status      = ST_FRAME;
        w.frame_start = fs;
        w.frame_end   = fe;
        w.frame_bytes = len;
        w.last_in_run = last;
        return w;
    endfunction

    // 32 kHz frames are one and a half times the 48 kHz ones
    function automatic logic [11:0] frame_len_bytes(input logic [1:0] rate,
                                                    input logic [5:0] code);
        int words;
        case (rate)
            RATE_48K: words = words_48k[code[5:1]];
            RATE_44K: words = words_44k[code[5:1]] + code[0];
            RATE_32K: words = words_48k[code[5:1]] * 3 / 2;
            default:  words = 0;
        endcase
        return 12'(2 * words);
    endfunction

    // predictor: queue the words that one accepted input word must produce
    task automatic deframe_word(input in_word_t w);
        logic [1:0]  rate;
        logic [5:0]  code;
        logic [11:0] len;
        rate = w.data_byte[7:6];
        code = w.data_byte[5:0];
        if (w.stream_end)
        begin
            due_words.push_back(status_word((hdr_fill == 0 && body_left == 0) ?
                                            ST_END : ST_TRUNC));
            hdr_fill  = 0;
            body_left = 0;
            body_len  = '0;
        end
        else if (body_left != 0)
        begin
            body_left--;
            due_words.push_back(frame_word(w.data_byte, 1'b0, body_left == 0, body_len, 1'b1));
            if (body_left == 0)
                body_len = '0;
        end
        else if (hdr_fill < 4)
        begin
            hdr_held[hdr_fill] = w.data_byte;
            hdr_fill++;
        end
        else
        begin
            // fifth header byte: sync, then rate, then size
            hdr_fill = 0;
            if (hdr_held[0] != SYNC_HI || hdr_held[1] != SYNC_LO)
                due_words.push_back(status_word(ST_BAD_SYNC));
            else if (rate == RATE_BAD)
                due_words.push_back(status_word(ST_BAD_RATE));
            else if (code > SIZE_CODE_MAX)
                due_words.push_back(status_word(ST_BAD_SIZE));
            else
            begin
                len       = frame_len_bytes(rate, code);
                body_len  = len;
                body_left = len - HDR_LEN;
                for (int k = 0; k < 4; k++)
                    due_words.push_back(frame_word(hdr_held[k], k == 0, 1'b0, len, 1'b0));
                due_words.push_back(frame_word(w.data_byte, 1'b0, 1'b0, len, 1'b1));
            end
        end
    endtask

    // offer one word, hold it until accepted, then predict
    task automatic push_word(input in_word_t w);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        item_count++;
        deframe_word(w);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_word({b, 1'b0});
    endtask

    task automatic send_end();
        push_word({8'($urandom), 1'b1});
    endtask

    // directed table: error codes, extremes and end-of-stream cases
    function automatic dir_row_t dir_row(input int idx);
        case (idx)
            0:       dir_row = {8'h00, 1'b1, 1'b1, ST_END};      // end right after reset
            1:       dir_row = {8'h00, 1'b0, 1'b0, ST_FRAME};
            2:       dir_row = {8'hFF, 1'b0, 1'b0, ST_FRAME};
            3:       dir_row = {8'h0B, 1'b0, 1'b0, ST_FRAME};
            4:       dir_row = {8'h77, 1'b0, 1'b0, ST_FRAME};
            5:       dir_row = {8'hFF, 1'b0, 1'b1, ST_BAD_SYNC};
            6:       dir_row = {8'h0B, 1'b0, 1'b0, ST_FRAME};
            7:       dir_row = {8'h77, 1'b0, 1'b0, ST_FRAME};
            8:       dir_row = {8'h00, 1'b0, 1'b0, ST_FRAME};
            9:       dir_row = {8'hFF, 1'b0, 1'b0, ST_FRAME};
            10:      dir_row = {8'hC0, 1'b0, 1'b1, ST_BAD_RATE}; // rate code 3
            11:      dir_row = {8'h0B, 1'b0, 1'b0, ST_FRAME};
            12:      dir_row = {8'h77, 1'b0, 1'b0, ST_FRAME};
            13:      dir_row = {8'hFF, 1'b0, 1'b0, ST_FRAME};
            14:      dir_row = {8'h00, 1'b0, 1'b0, ST_FRAME};
            15:      dir_row = {8'h26, 1'b0, 1'b1, ST_BAD_SIZE}; // size code 38
            16:      dir_row = {8'h0B, 1'b0, 1'b0, ST_FRAME};
            17:      dir_row = {8'h77, 1'b0, 1'b0, ST_FRAME};
            18:      dir_row = {8'h00, 1'b0, 1'b0, ST_FRAME};
            19:      dir_row = {8'h00, 1'b0, 1'b0, ST_FRAME};
            20:      dir_row = {8'hA5, 1'b0, 1'b0, ST_FRAME};    // 32 kHz, code 37: 3840 bytes
            21:      dir_row = {8'hFF, 1'b0, 1'b0, ST_FRAME};
            22:      dir_row = {8'h00, 1'b1, 1'b1, ST_TRUNC};    // end inside a body
            23:      dir_row = {8'h0B, 1'b0, 1'b0, ST_FRAME};
            default: dir_row = {8'hFF, 1'b1, 1'b1, ST_TRUNC};    // end inside a header
        endcase
    endfunction

    // one random stretch of stream: whole or cut-short frames, some broken or noisy
    task automatic run_random_case();
        logic [7:0] hdr [5];
        logic [1:0] rate;
        logic [5:0] code;
        int         pick;
        int         n;
        case ((item_count - DIR_ROWS) * 3 / RANDOM_ITEMS)
            0:       begin in_idle_pct = 15; out_idle_pct = 76; end
            1:       begin in_idle_pct = 76; out_idle_pct = 15; end
            default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        endcase
        pick   = $urandom_range(99);
        rate   = 2'($urandom_range(2));
        code   = 6'($urandom_range(3));   // short frames keep the run small
        hdr[0] = SYNC_HI;
        hdr[1] = SYNC_LO;
        hdr[2] = 8'($urandom);
        hdr[3] = 8'($urandom);
        hdr[4] = {rate, code};
        if (pick < 35)
        begin
            // whole frame, sometimes closed by a clean end
            for (int k = 0; k < HDR_LEN; k++)
                send_byte(hdr[k]);
            n = frame_len_bytes(rate, code) - HDR_LEN;
            for (int k = 0; k < n; k++)
                send_byte(8'($urandom));
            if ($urandom_range(2) == 0)
                send_end();
        end
        else if (pick < 55)
        begin
            // frame cut short by end of stream
            for (int k = 0; k < HDR_LEN; k++)
                send_byte(hdr[k]);
            n = $urandom_range(20);
            for (int k = 0; k < n; k++)
                send_byte(8'($urandom));
            send_end();
        end
        else if (pick < 75)
        begin
            // broken header: sync, rate or size
            case ($urandom_range(2))
                0:       hdr[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
                1:       hdr[4] = {RATE_BAD, 6'($urandom)};
                default: hdr[4] = {2'($urandom_range(2)), 6'($urandom_range(38, 63))};
            endcase
            for (int k = 0; k < HDR_LEN; k++)
                send_byte(hdr[k]);
        end
        else if (pick < 87)
        begin
            // end inside a header
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                send_byte(hdr[k]);
            send_end();
        end
        else if (pick < 93)
            send_end();
        else
        begin
            // noise, then an end to get back to a frame boundary
            n = $urandom_range(1, 9);
            for (int k = 0; k < n; k++)
                send_byte(8'($urandom));
            send_end();
        end
    endtask

    // reset and stimulus
    initial
    begin
        dir_row_t row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_row(i);
            push_word({row.data_byte, row.stream_end});
            if (row.typed)
                due_words[$] = status_word(row.st);
        end
        while (item_count < DIR_ROWS + RANDOM_ITEMS)
            run_random_case();
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ac3_syncframe_deframer verification clean");
        else
            $display("ac3_syncframe_deframer verification failed");
        $finish;
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic check_field(input string name, input logic [11:0] exp_val,
                               input logic [11:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // compare each accepted output word with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_words.size() == 0)
            begin
                $display("%0t: word %h with none due", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = due_words.pop_front();
                check_field("out_byte", 12'(want.out_byte), 12'(out_data.out_byte));
                check_field("status", 12'(want.status), 12'(out_data.status));
                check_field("frame_start", 12'(want.frame_start),
                            12'(out_data.frame_start));
                check_field("frame_end", 12'(want.frame_end), 12'(out_data.frame_end));
                check_field("frame_bytes", want.frame_bytes, out_data.frame_bytes);
                check_field("last_in_run", 12'(want.last_in_run),
                            12'(out_data.last_in_run));
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("ac3_syncframe_deframer verification failed");
            $finish;
        end
    end

endmodule
